[src/rx_gain_median_compensator_top_assert.svh]
// Assertion macros for the received-gain median compensator.
// Used by the top level; the macros expect signals named clk and rst_n in scope.
`ifndef RX_GAIN_MEDIAN_COMPENSATOR_TOP_ASSERT_SVH
`define RX_GAIN_MEDIAN_COMPENSATOR_TOP_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define RGMC_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define RGMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/rgmc_pkg.sv]
// Shared constants and helper functions for the received-gain median compensator.
// No dependencies; used by the top level.
package rgmc_pkg;

    localparam int RING_DEPTH_DEF = 50;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    localparam logic [1:0] FUNC_RECORD     = 2'd0;
    localparam logic [1:0] FUNC_COMPENSATE = 2'd1;
    localparam logic [1:0] FUNC_RESTART    = 2'd2;

    // 1.0 in Q4.28 and the reciprocal of ten for an exact 32-bit divide (>> 35).
    localparam logic [31:0] ONE_Q28 = 32'h1000_0000;
    localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

    // Offset that moves the attenuation exponent into a non-negative range.
    localparam logic signed [12:0] EXP_OFFSET = 13'sd1280;

    // 10^(2^k / 80) in Q4.28 for bit k of the fractional exponent.
    function automatic logic [31:0] pow_step(input logic [2:0] k);
        logic [31:0] v;
        case (k)
            3'd0:    v = 32'd276273913;
            3'd1:    v = 32'd284341257;
            3'd2:    v = 32'd301189535;
            3'd3:    v = 32'd337940217;
            3'd4:    v = 32'd425441527;
            3'd5:    v = 32'd674279380;
            3'd6:    v = 32'd1693713225;
            default: v = ONE_Q28;
        endcase
        return v;
    endfunction

endpackage

[src/rgmc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the ring of received gain pairs.
module rgmc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 50,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/rx_gain_median_compensator_top.sv]
// Received-gain median compensator. Record transfers (func 0) push an AGC/FFT gain pair into a
// ring of RING_DEPTH entries held in a RAM; restart transfers (func 2) zero the record count.
// A compensate transfer (func 1) answers with status 1 until RING_DEPTH records have been made
// since the last restart. Once the count is full and no baseline is held, the block finds the
// median AGC gain by a bitwise search over the ring (eight passes, each reading every entry
// once through the single RAM read port) and then scans for the first entry with that gain to
// pick up its FFT gain. The sample is scaled by 10^(-(4*dAGC+dFFT)/80), with the factor built
// in Q4.28 on one shared 32x32 multiplier that is reused for the table products, for the exact
// divide by ten and for the final sample product. An item that is not a ready compensate goes
// straight to the done state. A compensate with a baseline works through the seven table
// products (each in ST_POW then ST_POW_WB) and up to sixteen decade steps (a multiply by ten in
// ST_Q alone, a divide in ST_Q then ST_DIV_WB); without a baseline, the median walk and the
// FFT lookup scan come first. The input is not ready while an item is at work. Results wait
// in an output register, so the next input transfer is taken while a result is still waiting
// to be collected. The ring needs no clearing after reset, because a full record count means
// every entry has been written.
`include "rx_gain_median_compensator_top_assert.svh"

module rx_gain_median_compensator_top #(
    parameter int RING_DEPTH = rgmc_pkg::RING_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // agc_gain [7:0], fft_gain [15:8], sample [23:16]
    input  logic [rgmc_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // func [1:0]
    input  logic [1:0]                     s_axis_tuser,
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // scaled_sample [7:0], gain_factor [31:8]
    output logic [rgmc_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // status [0]
    output logic                           m_axis_tuser,
    output logic                           m_axis_tlast
);

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX   = AW'(RING_DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(RING_DEPTH);
    localparam logic [CW-1:0] RANK_COUNT = CW'(RING_DEPTH / 2);

    // Sequencer states.
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_MED      = 4'd1;
    localparam logic [3:0] ST_MED_END  = 4'd2;
    localparam logic [3:0] ST_FIND     = 4'd3;
    localparam logic [3:0] ST_T        = 4'd4;
    localparam logic [3:0] ST_QR       = 4'd5;
    localparam logic [3:0] ST_POW      = 4'd6;
    localparam logic [3:0] ST_POW_WB   = 4'd7;
    localparam logic [3:0] ST_Q        = 4'd8;
    localparam logic [3:0] ST_DIV_WB   = 4'd9;
    localparam logic [3:0] ST_GF       = 4'd10;
    localparam logic [3:0] ST_SCALE    = 4'd11;
    localparam logic [3:0] ST_SCALE_WB = 4'd12;
    localparam logic [3:0] ST_DONE     = 4'd13;

    // Control state.
    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [CW-1:0] records_reg, records_next;
    logic [7:0]    baseline_agc_reg, baseline_agc_next;
    logic [7:0]    baseline_fft_reg, baseline_fft_next;
    logic [AW-1:0] scan_idx_reg, scan_idx_next;
    logic          rd_pend_reg, rd_pend_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [2:0]    med_bit_reg, med_bit_next;
    logic [7:0]    med_val_reg, med_val_next;
    logic [2:0]    k_reg, k_next;
    logic signed [5:0] q_reg, q_next;
    logic          out_valid_reg, out_valid_next;

    // Item payload and datapath.
    logic [7:0]    agc_reg, agc_next;
    logic [7:0]    fft_reg, fft_next;
    logic [7:0]    smp_reg, smp_next;
    logic          last_reg, last_next;
    logic [11:0]   u_reg, u_next;
    logic [6:0]    r_reg, r_next;
    logic [39:0]   m_reg, m_next;
    logic [63:0]   prod_reg;
    logic [23:0]   gain_reg, gain_next;
    logic          w_status_reg, w_status_next;
    logic [7:0]    w_scaled_reg, w_scaled_next;
    logic [23:0]   w_gain_reg, w_gain_next;
    logic          out_status_reg, out_status_next;
    logic [7:0]    out_scaled_reg, out_scaled_next;
    logic [23:0]   out_gain_reg, out_gain_next;
    logic          out_last_reg, out_last_next;

    logic          accept;
    logic [AW-1:0] wp_inc;
    logic          ring_we;
    logic [15:0]   ring_rdata;
    logic [7:0]    rd_agc;
    logic [7:0]    rd_fft;
    logic [7:0]    trial;
    logic          trial_hit;
    logic [CW-1:0] cnt_sum;
    logic [31:0]   mul_a;
    logic [31:0]   mul_b;
    logic [7:0]    smp_mag;
    logic [15:0]   scale_mag;
    logic signed [12:0] neg_dagc4;
    logic signed [12:0] neg_dfft;
    logic signed [12:0] u_sum;
    logic [14:0]   q_prod;
    logic [4:0]    q_raw;
    logic [11:0]   q_times80;
    logic [11:0]   r_wide;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign wp_inc        = (wp_reg == LAST_IDX) ? '0 : wp_reg + AW'(1);
    assign ring_we       = accept && (s_axis_tuser == rgmc_pkg::FUNC_RECORD);

    rgmc_ram #(
        .WIDTH (16),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (wp_inc),
        .wdata (s_axis_tdata[15:0]),
        .raddr (scan_idx_reg),
        .rdata (ring_rdata)
    );

    assign rd_agc = ring_rdata[7:0];
    assign rd_fft = ring_rdata[15:8];

    // Median search: the result is the largest value whose count of smaller entries does not
    // exceed the rank, built one bit at a time from the top.
    assign trial     = med_val_reg | (8'd1 << med_bit_reg);
    assign trial_hit = rd_pend_reg && (rd_agc < trial);
    assign cnt_sum   = cnt_reg + CW'(trial_hit);

    // Exponent u = 1280 - (4*dAGC + dFFT), always within 5..2555.
    assign neg_dagc4 = ($signed({5'b0, baseline_agc_reg}) - $signed({5'b0, agc_reg})) <<< 2;
    assign neg_dfft  = $signed({{5{baseline_fft_reg[7]}}, baseline_fft_reg})
                     - $signed({{5{fft_reg[7]}}, fft_reg});
    assign u_sum     = neg_dagc4 + neg_dfft + rgmc_pkg::EXP_OFFSET;

    // u / 80 as (u / 16) / 5, the divide by five by a reciprocal that is exact below 160.
    assign q_prod    = {7'b0, u_reg[11:4]} * 15'd205;
    assign q_raw     = q_prod[14:10];
    assign q_times80 = {1'b0, q_raw, 6'b0} + {3'b0, q_raw, 4'b0};
    assign r_wide    = u_reg - q_times80;

    assign smp_mag   = smp_reg[7] ? (8'd0 - smp_reg) : smp_reg;
    assign scale_mag = prod_reg[31:16];

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = m_reg[31:0];
        mul_b = rgmc_pkg::RECIP10;
        case (state_reg)
            ST_POW:
            begin
                mul_b = r_reg[0] ? rgmc_pkg::pow_step(k_reg) : rgmc_pkg::ONE_Q28;
            end
            ST_SCALE:
            begin
                mul_a = {24'b0, smp_mag};
                mul_b = {8'b0, gain_reg};
            end
            default:
            begin
                mul_a = m_reg[31:0];
            end
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        wp_next           = wp_reg;
        records_next      = records_reg;
        baseline_agc_next = baseline_agc_reg;
        baseline_fft_next = baseline_fft_reg;
        scan_idx_next     = scan_idx_reg;
        rd_pend_next      = (state_reg == ST_MED) || (state_reg == ST_FIND);
        cnt_next          = cnt_reg;
        med_bit_next      = med_bit_reg;
        med_val_next      = med_val_reg;
        k_next            = k_reg;
        q_next            = q_reg;
        agc_next          = agc_reg;
        fft_next          = fft_reg;
        smp_next          = smp_reg;
        last_next         = last_reg;
        u_next            = u_reg;
        r_next            = r_reg;
        m_next            = m_reg;
        gain_next         = gain_reg;
        w_status_next     = w_status_reg;
        w_scaled_next     = w_scaled_reg;
        w_gain_next       = w_gain_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    agc_next      = s_axis_tdata[7:0];
                    fft_next      = s_axis_tdata[15:8];
                    smp_next      = s_axis_tdata[23:16];
                    last_next     = s_axis_tlast;
                    w_status_next = 1'b0;
                    w_scaled_next = 8'd0;
                    w_gain_next   = 24'd0;
                    state_next    = ST_DONE;
                    case (s_axis_tuser)
                        rgmc_pkg::FUNC_RECORD:
                        begin
                            wp_next = wp_inc;
                            if (records_reg < FULL_COUNT)
                            begin
                                records_next = records_reg + CW'(1);
                            end
                        end
                        rgmc_pkg::FUNC_RESTART:
                        begin
                            records_next = '0;
                        end
                        rgmc_pkg::FUNC_COMPENSATE:
                        begin
                            if (records_reg < FULL_COUNT)
                            begin
                                baseline_agc_next = 8'd0;
                                baseline_fft_next = 8'd0;
                                w_status_next     = 1'b1;
                            end
                            else if ((baseline_agc_reg == 8'd0) && (baseline_fft_reg == 8'd0))
                            begin
                                med_val_next  = 8'd0;
                                med_bit_next  = 3'd7;
                                scan_idx_next = '0;
                                cnt_next      = '0;
                                state_next    = ST_MED;
                            end
                            else
                            begin
                                state_next = ST_T;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_MED:
            begin
                cnt_next = cnt_sum;
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = ST_MED_END;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + AW'(1);
                end
            end

            ST_MED_END:
            begin
                // The last read of the pass lands here.
                if (cnt_sum <= RANK_COUNT)
                begin
                    med_val_next = trial;
                end
                scan_idx_next = '0;
                cnt_next      = '0;
                if (med_bit_reg == 3'd0)
                begin
                    state_next = ST_FIND;
                end
                else
                begin
                    med_bit_next = med_bit_reg - 3'd1;
                    state_next   = ST_MED;
                end
            end

            ST_FIND:
            begin
                if (rd_pend_reg && (rd_agc == med_val_reg))
                begin
                    baseline_agc_next = med_val_reg;
                    baseline_fft_next = rd_fft;
                    state_next        = ST_T;
                end
                else if (scan_idx_reg != LAST_IDX)
                begin
                    scan_idx_next = scan_idx_reg + AW'(1);
                end
            end

            ST_T:
            begin
                u_next     = u_sum[11:0];
                state_next = ST_QR;
            end

            ST_QR:
            begin
                q_next     = $signed({1'b0, q_raw}) - 6'sd16;
                r_next     = r_wide[6:0];
                m_next     = {8'b0, rgmc_pkg::ONE_Q28};
                k_next     = 3'd0;
                state_next = ST_POW;
            end

            ST_POW:
            begin
                state_next = ST_POW_WB;
            end

            ST_POW_WB:
            begin
                m_next = {8'b0, prod_reg[59:28]};
                r_next = r_reg >> 1;
                if (k_reg == 3'd6)
                begin
                    state_next = ST_Q;
                end
                else
                begin
                    k_next     = k_reg + 3'd1;
                    state_next = ST_POW;
                end
            end

            ST_Q:
            begin
                if (q_reg[5])
                begin
                    state_next = ST_DIV_WB;
                end
                else if ((q_reg == 6'sd0) || (m_reg[39:36] != 4'd0))
                begin
                    state_next = ST_GF;
                end
                else
                begin
                    m_next = (m_reg << 3) + (m_reg << 1);
                    q_next = q_reg - 6'sd1;
                end
            end

            ST_DIV_WB:
            begin
                m_next     = {11'b0, prod_reg[63:35]};
                q_next     = q_reg + 6'sd1;
                state_next = ST_Q;
            end

            ST_GF:
            begin
                gain_next   = (m_reg[39:36] != 4'd0) ? 24'hFF_FFFF : m_reg[35:12];
                w_gain_next = (m_reg[39:36] != 4'd0) ? 24'hFF_FFFF : m_reg[35:12];
                state_next  = ST_SCALE;
            end

            ST_SCALE:
            begin
                state_next = ST_SCALE_WB;
            end

            ST_SCALE_WB:
            begin
                if (!smp_reg[7])
                begin
                    w_scaled_next = (scale_mag > 16'd127) ? 8'h7F : scale_mag[7:0];
                end
                else
                begin
                    w_scaled_next = (scale_mag > 16'd128) ? 8'h80 : (8'd0 - scale_mag[7:0]);
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: loaded from the work registers when the slot is free or draining.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_scaled_next = out_scaled_reg;
        out_gain_next   = out_gain_reg;
        out_last_next   = out_last_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if ((state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready))
        begin
            out_valid_next  = 1'b1;
            out_status_next = w_status_reg;
            out_scaled_next = w_scaled_reg;
            out_gain_next   = w_gain_reg;
            out_last_next   = last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            wp_reg           <= '0;
            records_reg      <= '0;
            baseline_agc_reg <= 8'd0;
            baseline_fft_reg <= 8'd0;
            scan_idx_reg     <= '0;
            rd_pend_reg      <= 1'b0;
            cnt_reg          <= '0;
            med_bit_reg      <= 3'd0;
            med_val_reg      <= 8'd0;
            k_reg            <= 3'd0;
            q_reg            <= 6'sd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            wp_reg           <= wp_next;
            records_reg      <= records_next;
            baseline_agc_reg <= baseline_agc_next;
            baseline_fft_reg <= baseline_fft_next;
            scan_idx_reg     <= scan_idx_next;
            rd_pend_reg      <= rd_pend_next;
            cnt_reg          <= cnt_next;
            med_bit_reg      <= med_bit_next;
            med_val_reg      <= med_val_next;
            k_reg            <= k_next;
            q_reg            <= q_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        agc_reg        <= agc_next;
        fft_reg        <= fft_next;
        smp_reg        <= smp_next;
        last_reg       <= last_next;
        u_reg          <= u_next;
        r_reg          <= r_next;
        m_reg          <= m_next;
        prod_reg       <= {32'b0, mul_a} * {32'b0, mul_b};
        gain_reg       <= gain_next;
        w_status_reg   <= w_status_next;
        w_scaled_reg   <= w_scaled_next;
        w_gain_reg     <= w_gain_next;
        out_status_reg <= out_status_next;
        out_scaled_reg <= out_scaled_next;
        out_gain_reg   <= out_gain_next;
        out_last_reg   <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_gain_reg, out_scaled_reg};
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

    // Once an item is taken, no further transfer is accepted until its result is queued.
    `RGMC_ASSERT_NEXT(a_accept_blocks, accept, !s_axis_tready, "input taken while busy")

    // A compensate before the ring is full must produce a not-ready result.
    `RGMC_ASSERT_NEXT(a_not_ready_status,
        accept && (s_axis_tuser == rgmc_pkg::FUNC_COMPENSATE) && (records_reg < FULL_COUNT),
        (state_reg == ST_DONE) && w_status_reg, "early compensate not flagged")

    // The reciprocal divide is exact only for operands below 2^32.
    `RGMC_ASSERT_IMPLIES(a_div_operand_narrow, (state_reg == ST_Q) && q_reg[5],
        m_reg[39:32] == 8'd0, "divide operand too wide")

    // A match in the lookup scan latches the median as the AGC baseline.
    `RGMC_ASSERT_NEXT(a_find_latch,
        (state_reg == ST_FIND) && rd_pend_reg && (rd_agc == med_val_reg),
        (state_reg == ST_T) && (baseline_agc_reg == $past(med_val_reg)),
        "median not latched as baseline")

endmodule
